/* rtl/core/fpa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the fixed-point ALU
// Operation codes, status codes and default fraction width.
// ----------------------------------------------------------------------------
package fpa_pkg;
  localparam int unsigned FractionBitsDefault = 8;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MIN = 3'd4;
  localparam logic [2:0] OP_MAX = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic       less;
    logic       equal;
    logic       greater;
  } cmp_flags_t;
endpackage
`default_nettype wire

/* rtl/core/fixed_point_q24_8_alu_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top: pipelined signed Q24.8 fixed-point ALU
// Add, subtract, multiply, divide, minimum and maximum on raw 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries operation, operand_a, operand_b.
//   Result channel out_valid/out_stall carries result, status and the
//   a-versus-b compare flags. A word moves on a clock edge with valid high
//   and stall low. Every input word yields exactly one result word.
//   Every operation runs through the same pipeline so order is kept: one
//   prep register, 64 divider stages (one quotient bit per stage over the
//   64-bit widened dividend) and the output register, with the finish logic
//   in front of it. Throughput is one word per cycle while the output is not
//   stalled; the multiplier sits in the prep stage and its product is
//   registered before the shift and range check.
//   When out_stall is high and the output register is full, the whole
//   pipeline holds (in_stall follows), so nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top #(
  parameter int unsigned FRACTION_BITS = fpa_pkg::FractionBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_operation,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result,
  output logic [1:0]              out_status,
  output logic                    out_a_less_b,
  output logic                    out_a_equal_b,
  output logic                    out_a_greater_b
);
  import fpa_pkg::*;

  localparam int unsigned SideW = 3 + 3 + 1 + 1 + 32 + 64;

  // Advance the pipeline unless a held result blocks the output.
  logic adv;
  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  // Prep stage: compare, add/sub, min/max, product, divider operands.
  logic              p_vld_r;
  logic [2:0]        p_op_r;
  cmp_flags_t        p_cmp_r;
  logic signed [32:0] p_sum_r;
  logic signed [31:0] p_sel_r;
  logic signed [63:0] p_prod_r;
  logic [63:0]       p_num_r;
  logic [31:0]       p_den_r;
  logic              p_neg_r;
  logic              p_bz_r;

  logic signed [63:0] a_wide;
  logic [63:0]        a_mag;
  logic [31:0]        b_mag;
  cmp_flags_t         cmp_nxt;
  assign a_wide = 64'(in_operand_a) <<< FRACTION_BITS;
  assign a_mag  = a_wide[63] ? 64'(-a_wide) : 64'(a_wide);
  assign b_mag  = in_operand_b[31] ? 32'(-in_operand_b) : 32'(in_operand_b);
  assign cmp_nxt = '{less:    in_operand_a <  in_operand_b,
                     equal:   in_operand_a == in_operand_b,
                     greater: in_operand_a >  in_operand_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_op_r   <= in_operation;
      p_cmp_r  <= cmp_nxt;
      p_sum_r  <= (in_operation == OP_SUB) ? 33'(in_operand_a) - 33'(in_operand_b)
                                           : 33'(in_operand_a) + 33'(in_operand_b);
      p_sel_r  <= ((in_operation == OP_MIN) == cmp_nxt.less) ? in_operand_a
                                                             : in_operand_b;
      p_prod_r <= 64'(in_operand_a) * 64'(in_operand_b);
      p_num_r  <= a_mag;
      p_den_r  <= b_mag;
      p_neg_r  <= in_operand_a[31] ^ in_operand_b[31];
      p_bz_r   <= (in_operand_b == '0);
    end
  end

  // Divider stages; everything else rides along as side data.
  logic [SideW-1:0] side_in, side_out;
  logic             d_vld;
  logic [63:0]      d_quo;
  assign side_in = {p_op_r, p_cmp_r, p_neg_r, p_bz_r, p_sel_r, p_prod_r};

  fpa_div #(.NumW(64), .DenW(32), .SideW(SideW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (p_vld_r),
    .in_num   (p_num_r),
    .in_den   (p_den_r),
    .in_side  (side_in),
    .out_vld  (d_vld),
    .out_quo  (d_quo),
    .out_side (side_out)
  );

  // Delay the sum through a line as deep as the divider.
  logic signed [32:0] sum_line_r [64];
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_line_r[0] <= p_sum_r;
      for (int k = 1; k < 64; k++) begin
        sum_line_r[k] <= sum_line_r[k-1];
      end
    end
  end

  logic [2:0]         f_op;
  cmp_flags_t         f_cmp;
  logic               f_neg, f_bz;
  logic signed [31:0] f_sel;
  logic signed [63:0] f_prod;
  assign {f_op, f_cmp, f_neg, f_bz, f_sel, f_prod} = side_out;

  // Finish stage: shift, sign restore, range check, select.
  logic signed [63:0] mul_sh, quo_s;
  logic signed [63:0] wide;
  logic               chk;
  logic signed [31:0] res_nxt;
  logic [1:0]         st_nxt;
  assign mul_sh = f_prod >>> FRACTION_BITS;
  assign quo_s  = f_neg ? 64'(-d_quo) : 64'(d_quo);

  always_comb begin
    wide    = '0;
    chk     = 1'b0;
    res_nxt = '0;
    st_nxt  = ST_OK;
    case (f_op) inside
      OP_ADD, OP_SUB: begin
        wide = 64'(sum_line_r[63]);
        chk  = 1'b1;
      end
      OP_MUL: begin
        wide = mul_sh;
        chk  = 1'b1;
      end
      OP_DIV: begin
        if (f_bz) begin
          st_nxt = ST_DIV_ZERO;
        end else begin
          wide = quo_s;
          chk  = 1'b1;
        end
      end
      OP_MIN, OP_MAX: res_nxt = f_sel;
      default: res_nxt = '0;
    endcase
    if (chk) begin
      if (wide[63:31] == {33{wide[31]}}) begin
        res_nxt = wide[31:0];
      end else begin
        st_nxt = ST_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result      <= res_nxt;
      out_status      <= st_nxt;
      out_a_less_b    <= f_cmp.less;
      out_a_equal_b   <= f_cmp.equal;
      out_a_greater_b <= f_cmp.greater;
    end
  end

`ifndef ASSERT_OFF
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less_b, out_a_equal_b, out_a_greater_b}))
    else $error("compare flags not one-hot");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result == '0)
    else $error("nonzero result with error status");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(p_vld_r))
    else $error("pipeline moved while stalled");
`endif
endmodule
`default_nettype wire

/* rtl/core/fpa_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div: pipelined restoring divider
// Unsigned 64/32 division, one quotient bit per stage, with stall support.
// Side data travels alongside the quotient.
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int unsigned NumW  = 64,
  parameter int unsigned DenW  = 32,
  parameter int unsigned SideW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_vld,
  input  wire logic [NumW-1:0]  in_num,
  input  wire logic [DenW-1:0]  in_den,
  input  wire logic [SideW-1:0] in_side,
  output logic                  out_vld,
  output logic [NumW-1:0]       out_quo,
  output logic [SideW-1:0]      out_side
);
  // Stage k holds partial remainder, shifting numerator/quotient word.
  logic             vld_r  [1:NumW];
  logic [DenW:0]    rem_r  [1:NumW];
  logic [NumW-1:0]  nq_r   [1:NumW];
  logic [DenW-1:0]  den_r  [1:NumW];
  logic [SideW-1:0] side_r [1:NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic             vld_in;
    logic [DenW:0]    rem_in;
    logic [NumW-1:0]  nq_in;
    logic [DenW-1:0]  den_in;
    logic [SideW-1:0] side_in;
    logic [DenW+1:0]  trial;
    logic [DenW:0]    rem_nxt;
    logic             bit_nxt;
    if (k == 0) begin : g_head
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign nq_in   = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld_r[k];
      assign rem_in  = rem_r[k];
      assign nq_in   = nq_r[k];
      assign den_in  = den_r[k];
      assign side_in = side_r[k];
    end
    always_comb begin
      trial   = {rem_in, nq_in[NumW-1]} - {2'b00, den_in};
      bit_nxt = ~trial[DenW+1];
      rem_nxt = bit_nxt ? trial[DenW:0] : {rem_in[DenW-1:0], nq_in[NumW-1]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= rem_nxt;
        nq_r[k+1]   <= {nq_in[NumW-2:0], bit_nxt};
        den_r[k+1]  <= den_in;
        side_r[k+1] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[NumW];
  assign out_quo  = nq_r[NumW];
  assign out_side = side_r[NumW];
endmodule
`default_nettype wire
